FILE: sv/ibci_pkg.sv
// Shared types, constants and helpers for the IMU bias calibration and integration block.
`timescale 1ns / 1ps

package ibci_pkg;

  // Field and storage widths.
  localparam int NUM_AXES      = 6;
  localparam int RAW_W         = 16;
  localparam int SCALE_W       = 24;
  localparam int GRAV_W        = 21;
  localparam int CNT_W         = 10;
  localparam int TICK_W        = 32;
  localparam int OUT_W         = 32;
  localparam int ANGLE_W       = 64;
  localparam int SUM_W         = 42;
  localparam int PROD_W        = RAW_W + SCALE_W + 1;
  localparam int DIVISOR_W     = CNT_W + 1;
  localparam int DIV_STEPS     = SUM_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
  localparam int COEF_FRAC     = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int REG_IDX_W     = 2;
  localparam int REG_DATA_W    = 24;

  // Configuration register reset values.
  localparam logic [CNT_W-1:0]   CAL_SAMPLES_RST = CNT_W'(100);
  localparam logic [SCALE_W-1:0] ACCEL_SCALE_RST = SCALE_W'(2571633);
  localparam logic [SCALE_W-1:0] GYRO_SCALE_RST  = SCALE_W'(572224);
  localparam logic [GRAV_W-1:0]  GRAVITY_RST     = GRAV_W'(642908);

  // Item action codes.
  typedef enum logic [1:0] {
    ACT_CAL  = 2'd0,
    ACT_MEAS = 2'd1,
    ACT_DIS  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  // Configuration register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_CAL_SAMPLES = 2'd0,
    REG_ACCEL_SCALE = 2'd1,
    REG_GYRO_SCALE  = 2'd2,
    REG_GRAVITY     = 2'd3
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_CORR,
    ST_DIV,
    ST_BIAS,
    ST_MUL,
    ST_ACC,
    ST_PUSH
  } state_t;

  // Controls from the sequencer to every lane.
  typedef struct packed {
    logic load;
    logic do_scale;
    logic do_corr;
    logic cal_item;
    logic cal_finish;
    logic div_step;
    logic bias_wr;
  } lane_ctrl_t;

  // Controls from the sequencer to the merge stage.
  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic push;
    logic measure;
    logic disable_item;
    logic done;
  } merge_ctrl_t;

  // Saturate a wide signed value to signed 32 bits.
  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [SUM_W:0] v);
    logic signed [SUM_W:0] hi;
    logic signed [SUM_W:0] lo;
    hi = (SUM_W+1)'(64'sd2147483647);
    lo = -(SUM_W+1)'(64'sd2147483648);
    if (v > hi) begin
      sat32 = OUT_W'(hi);
    end else if (v < lo) begin
      sat32 = OUT_W'(lo);
    end else begin
      sat32 = v[OUT_W-1:0];
    end
  endfunction

endpackage

FILE: sv/ibci_lane.sv
// One axis lane: scaling, bias correction, calibration sum and a serial bias divider.
`timescale 1ns / 1ps

module ibci_lane #(
  parameter int FRAC_BITS = ibci_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ibci_pkg::lane_ctrl_t                 ctrl,
  input  logic signed [ibci_pkg::RAW_W-1:0]    raw,
  input  logic [ibci_pkg::SCALE_W-1:0]         coef,
  input  logic [ibci_pkg::GRAV_W-1:0]          grav,
  input  logic [ibci_pkg::DIVISOR_W-1:0]       divisor,
  output logic signed [ibci_pkg::OUT_W-1:0]    corr
);

  localparam int SHIFT = ibci_pkg::COEF_FRAC - FRAC_BITS;
  localparam int SW    = ibci_pkg::SUM_W;
  localparam int PW    = ibci_pkg::PROD_W;
  localparam int OW    = ibci_pkg::OUT_W;
  localparam int DW    = ibci_pkg::DIVISOR_W;
  localparam logic signed [SW-1:0] RND = SW'(1) << (SHIFT - 1);

  logic signed [ibci_pkg::RAW_W-1:0] raw_q;
  logic signed [PW-1:0]              prod_q;
  logic signed [OW-1:0]              bias;
  logic signed [SW-1:0]              cal_sum;
  logic [SW-1:0]                     quo_q;
  logic [DW-1:0]                     rem_q;
  logic                              neg_q;

  logic signed [SW-1:0] scaled;
  logic signed [SW:0]   diff_bias;
  logic signed [SW:0]   diff_grav;
  logic signed [OW-1:0] unbiased;
  logic signed [SW-1:0] sum_new;
  logic [SW-1:0]        sum_mag;
  logic [DW:0]          rem_sh;
  logic [DW:0]          rem_sub;

  // Round half up and drop the coefficient fraction bits beyond FRAC_BITS.
  always_comb begin
    scaled    = ($signed({{(SW-PW){prod_q[PW-1]}}, prod_q}) + RND) >>> SHIFT;
    diff_bias = {scaled[SW-1], scaled} - {{(SW+1-OW){bias[OW-1]}}, bias};
    diff_grav = {scaled[SW-1], scaled} - $signed({{(SW+1-ibci_pkg::GRAV_W){1'b0}}, grav});
    unbiased  = ibci_pkg::sat32(diff_grav);
    sum_new   = cal_sum + {{(SW-OW){unbiased[OW-1]}}, unbiased};
    sum_mag   = sum_new[SW-1] ? SW'(-sum_new) : sum_new;
    rem_sh    = {rem_q, quo_q[SW-1]};
    rem_sub   = rem_sh - {1'b0, divisor};
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      raw_q <= raw;
    end
    if (ctrl.do_scale) begin
      prod_q <= $signed({{(PW-ibci_pkg::RAW_W){raw_q[ibci_pkg::RAW_W-1]}}, raw_q}) *
                $signed({{(PW-ibci_pkg::SCALE_W){1'b0}}, coef});
    end
    if (ctrl.do_corr) begin
      corr <= ibci_pkg::sat32(diff_bias);
      if (ctrl.cal_item && ctrl.cal_finish) begin
        quo_q <= sum_mag;
        neg_q <= sum_new[SW-1];
        rem_q <= '0;
      end
    end else if (ctrl.div_step) begin
      // Restoring division, one quotient bit a cycle.
      if (rem_sh >= {1'b0, divisor}) begin
        rem_q <= rem_sub[DW-1:0];
        quo_q <= {quo_q[SW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DW-1:0];
        quo_q <= {quo_q[SW-2:0], 1'b0};
      end
    end
  end

  // Calibration sum and bias state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_sum <= '0;
      bias    <= '0;
    end else begin
      if (ctrl.do_corr && ctrl.cal_item) begin
        cal_sum <= ctrl.cal_finish ? '0 : sum_new;
      end
      if (ctrl.bias_wr) begin
        bias <= neg_q ? -$signed(quo_q[OW-1:0]) : $signed(quo_q[OW-1:0]);
      end
    end
  end

endmodule

FILE: sv/ibci_merge.sv
// Merge stage: gyro x angle integration and the result register.
`timescale 1ns / 1ps

module ibci_merge (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  ibci_pkg::merge_ctrl_t                                   ctrl,
  input  logic [ibci_pkg::TICK_W-1:0]                             tick,
  input  logic [ibci_pkg::NUM_AXES-1:0][ibci_pkg::OUT_W-1:0]      corr,
  input  logic                                                    out_stall,
  output logic                                                    out_free,
  output logic                                                    out_valid,
  output logic [ibci_pkg::NUM_AXES-1:0][ibci_pkg::OUT_W-1:0]      res_corr,
  output logic [ibci_pkg::ANGLE_W-1:0]                            res_angle,
  output logic                                                    res_done
);

  localparam int AW = ibci_pkg::ANGLE_W;
  localparam int TW = ibci_pkg::TICK_W;
  localparam int OW = ibci_pkg::OUT_W;

  logic [TW-1:0] tick_q;
  logic [TW-1:0] prev_tick;
  logic [AW-1:0] prod_q;
  logic [AW-1:0] angle_acc;
  logic          integrating;
  logic [TW-1:0] dt;
  logic [OW-1:0] gx;

  assign gx       = corr[3];
  assign dt       = tick_q - prev_tick;
  assign out_free = !out_valid || !out_stall;

  // Item tick, the product of corrected gyro x and the tick delta, and the result register.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      tick_q <= tick;
    end
    if (ctrl.mul) begin
      prod_q <= $signed({{(AW-OW){gx[OW-1]}}, gx}) * $signed({{(AW-TW){1'b0}}, dt});
    end
    if (ctrl.push) begin
      res_corr  <= corr;
      res_angle <= ctrl.measure && integrating ? angle_acc : angle_acc;
      res_done  <= ctrl.done;
    end
  end

  // Integration state.
  always_ff @(posedge clk) begin
    if (rst) begin
      integrating <= 1'b0;
      prev_tick   <= '0;
      angle_acc   <= '0;
    end else if (ctrl.acc) begin
      if (ctrl.measure) begin
        if (integrating) begin
          angle_acc <= angle_acc + prod_q;
        end
        integrating <= 1'b1;
        prev_tick   <= tick_q;
      end else if (ctrl.disable_item) begin
        integrating <= 1'b0;
      end
    end
  end

  // Result register handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: sv/imu_bias_calibrate_integrate_unit.sv
// Top level: IMU bias calibration and gyro integration with six parallel axis lanes.
//
// Input channel: action, six raw counts and a tick, under in_valid / in_stall.
// Output channel: six corrected axes, the integrated angle and cal_done,
// under out_valid / out_stall. Configuration registers are written through
// wr_en / wr_index / wr_data; the user must write them only while the block is
// idle, which the block itself does not enforce. An item is taken only while the
// sequencer is idle. An ordinary item passes the scale, correct, multiply,
// accumulate and push states before the next item can be taken in idle. The
// calibrate item that completes an average also runs the lanes' serial dividers,
// one quotient bit a cycle for all 42 quotient bits, then a bias write.
// The result sits in an output register, so a new item is accepted while an
// earlier result still waits; if the receiver stalls and the register is
// still full when the next result is ready, the sequencer holds that result
// and keeps in_stall high until the register frees.
// Synchronous reset clears the biases, sums, count, angle and integration
// flag, empties the output register and loads the register defaults.
`timescale 1ns / 1ps

module imu_bias_calibrate_integrate_unit #(
  parameter int FRAC_BITS = ibci_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             action,
  input  logic signed [ibci_pkg::RAW_W-1:0]      raw_accel_x,
  input  logic signed [ibci_pkg::RAW_W-1:0]      raw_accel_y,
  input  logic signed [ibci_pkg::RAW_W-1:0]      raw_accel_z,
  input  logic signed [ibci_pkg::RAW_W-1:0]      raw_gyro_x,
  input  logic signed [ibci_pkg::RAW_W-1:0]      raw_gyro_y,
  input  logic signed [ibci_pkg::RAW_W-1:0]      raw_gyro_z,
  input  logic [ibci_pkg::TICK_W-1:0]            tick,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [ibci_pkg::OUT_W-1:0]      accel_x_out,
  output logic signed [ibci_pkg::OUT_W-1:0]      accel_y_out,
  output logic signed [ibci_pkg::OUT_W-1:0]      accel_z_out,
  output logic signed [ibci_pkg::OUT_W-1:0]      gyro_x_out,
  output logic signed [ibci_pkg::OUT_W-1:0]      gyro_y_out,
  output logic signed [ibci_pkg::OUT_W-1:0]      gyro_z_out,
  output logic signed [ibci_pkg::ANGLE_W-1:0]    angle,
  output logic                                   cal_done,
  input  logic                                   wr_en,
  input  logic [ibci_pkg::REG_IDX_W-1:0]         wr_index,
  input  logic [ibci_pkg::REG_DATA_W-1:0]        wr_data
);

  localparam int NA = ibci_pkg::NUM_AXES;
  localparam int CW = ibci_pkg::CNT_W;
  localparam int DW = ibci_pkg::DIVISOR_W;
  localparam logic [ibci_pkg::DIV_CNT_W-1:0] DIV_LAST =
    ibci_pkg::DIV_CNT_W'(ibci_pkg::DIV_STEPS - 1);

  ibci_pkg::state_t state;
  ibci_pkg::state_t state_next;
  ibci_pkg::action_t action_q;

  logic [CW-1:0]                    cal_samples;
  logic [ibci_pkg::SCALE_W-1:0]     accel_scale;
  logic [ibci_pkg::SCALE_W-1:0]     gyro_scale;
  logic [ibci_pkg::GRAV_W-1:0]      gravity_offset;
  logic [CW-1:0]                    cal_count;
  logic [DW-1:0]                    div_n;
  logic [ibci_pkg::DIV_CNT_W-1:0]   div_cnt;
  logic                             done_q;

  logic [CW-1:0]                    target;
  logic [DW-1:0]                    n_next;
  logic                             cal_finish;
  logic                             out_free;
  ibci_pkg::lane_ctrl_t             lane_ctrl;
  ibci_pkg::merge_ctrl_t            merge_ctrl;

  logic [NA-1:0][ibci_pkg::RAW_W-1:0] raw_all;
  logic [NA-1:0][ibci_pkg::OUT_W-1:0] corr_all;
  logic [NA-1:0][ibci_pkg::OUT_W-1:0] res_corr;
  logic [ibci_pkg::ANGLE_W-1:0]       res_angle;

  assign raw_all = {raw_gyro_z, raw_gyro_y, raw_gyro_x, raw_accel_z, raw_accel_y, raw_accel_x};

  // Calibration completion check; a zero sample count acts as one.
  always_comb begin
    target     = (cal_samples == '0) ? CW'(1) : cal_samples;
    n_next     = {1'b0, cal_count} + DW'(1);
    cal_finish = n_next >= {1'b0, target};
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ibci_pkg::ST_IDLE:  if (in_valid) state_next = ibci_pkg::ST_SCALE;
      ibci_pkg::ST_SCALE: state_next = ibci_pkg::ST_CORR;
      ibci_pkg::ST_CORR: begin
        if (action_q == ibci_pkg::ACT_CAL && cal_finish) begin
          state_next = ibci_pkg::ST_DIV;
        end else begin
          state_next = ibci_pkg::ST_MUL;
        end
      end
      ibci_pkg::ST_DIV:   if (div_cnt == DIV_LAST) state_next = ibci_pkg::ST_BIAS;
      ibci_pkg::ST_BIAS:  state_next = ibci_pkg::ST_MUL;
      ibci_pkg::ST_MUL:   state_next = ibci_pkg::ST_ACC;
      ibci_pkg::ST_ACC:   state_next = ibci_pkg::ST_PUSH;
      ibci_pkg::ST_PUSH:  if (out_free) state_next = ibci_pkg::ST_IDLE;
      default:            state_next = ibci_pkg::ST_IDLE;
    endcase
  end

  // Controls decoded from the state.
  always_comb begin
    in_stall                = (state != ibci_pkg::ST_IDLE);
    lane_ctrl.load          = (state == ibci_pkg::ST_IDLE) && in_valid;
    lane_ctrl.do_scale      = (state == ibci_pkg::ST_SCALE);
    lane_ctrl.do_corr       = (state == ibci_pkg::ST_CORR);
    lane_ctrl.cal_item      = (action_q == ibci_pkg::ACT_CAL);
    lane_ctrl.cal_finish    = cal_finish;
    lane_ctrl.div_step      = (state == ibci_pkg::ST_DIV);
    lane_ctrl.bias_wr       = (state == ibci_pkg::ST_BIAS);
    merge_ctrl.load         = lane_ctrl.load;
    merge_ctrl.mul          = (state == ibci_pkg::ST_MUL);
    merge_ctrl.acc          = (state == ibci_pkg::ST_ACC);
    merge_ctrl.push         = (state == ibci_pkg::ST_PUSH) && out_free;
    merge_ctrl.measure      = (action_q == ibci_pkg::ACT_MEAS);
    merge_ctrl.disable_item = (action_q == ibci_pkg::ACT_DIS);
    merge_ctrl.done         = done_q;
  end

  // Sequencer, calibration count and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ibci_pkg::ST_IDLE;
      action_q       <= ibci_pkg::ACT_NONE;
      cal_count      <= '0;
      div_n          <= DW'(1);
      div_cnt        <= '0;
      done_q         <= 1'b0;
      cal_samples    <= ibci_pkg::CAL_SAMPLES_RST;
      accel_scale    <= ibci_pkg::ACCEL_SCALE_RST;
      gyro_scale     <= ibci_pkg::GYRO_SCALE_RST;
      gravity_offset <= ibci_pkg::GRAVITY_RST;
    end else begin
      state <= state_next;
      if (lane_ctrl.load) begin
        action_q <= ibci_pkg::action_t'(action);
        done_q   <= 1'b0;
      end
      if (state == ibci_pkg::ST_CORR && action_q == ibci_pkg::ACT_CAL) begin
        if (cal_finish) begin
          cal_count <= '0;
          div_n     <= n_next;
          done_q    <= 1'b1;
        end else begin
          cal_count <= n_next[CW-1:0];
        end
      end
      if (state == ibci_pkg::ST_DIV) begin
        div_cnt <= (div_cnt == DIV_LAST) ? '0 : div_cnt + 1'b1;
      end
      if (wr_en) begin
        case (ibci_pkg::reg_idx_t'(wr_index))
          ibci_pkg::REG_CAL_SAMPLES: cal_samples    <= wr_data[CW-1:0];
          ibci_pkg::REG_ACCEL_SCALE: accel_scale    <= wr_data[ibci_pkg::SCALE_W-1:0];
          ibci_pkg::REG_GYRO_SCALE:  gyro_scale     <= wr_data[ibci_pkg::SCALE_W-1:0];
          ibci_pkg::REG_GRAVITY:     gravity_offset <= wr_data[ibci_pkg::GRAV_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Axis lanes: accel on lanes 0 to 2, gyro on lanes 3 to 5; gravity on accel x only.
  for (genvar i = 0; i < NA; i++) begin : g_lane
    ibci_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (lane_ctrl),
      .raw     (raw_all[i]),
      .coef    ((i < 3) ? accel_scale : gyro_scale),
      .grav    ((i == 0) ? gravity_offset : '0),
      .divisor (div_n),
      .corr    (corr_all[i])
    );
  end

  ibci_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (merge_ctrl),
    .tick      (tick),
    .corr      (corr_all),
    .out_stall (out_stall),
    .out_free  (out_free),
    .out_valid (out_valid),
    .res_corr  (res_corr),
    .res_angle (res_angle),
    .res_done  (cal_done)
  );

  assign accel_x_out = res_corr[0];
  assign accel_y_out = res_corr[1];
  assign accel_z_out = res_corr[2];
  assign gyro_x_out  = res_corr[3];
  assign gyro_y_out  = res_corr[4];
  assign gyro_z_out  = res_corr[5];
  assign angle       = res_angle;

  // A new result only appears after the push state.
  a_push_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ibci_pkg::ST_PUSH)
    else $error("result appeared outside the push state");

  // The divider runs only for a calibrate item that completes the average.
  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ibci_pkg::ST_DIV && $past(state) != ibci_pkg::ST_DIV) |->
      ($past(state) == ibci_pkg::ST_CORR && action_q == ibci_pkg::ACT_CAL && done_q))
    else $error("divider started without a completed calibration");

  // The bias write follows a full division.
  a_bias_after_div: assert property (@(posedge clk) disable iff (rst)
    state == ibci_pkg::ST_BIAS |-> ($past(state) == ibci_pkg::ST_DIV && $past(div_cnt) == DIV_LAST))
    else $error("bias written before the division finished");

  // The step counter rests at zero outside the division.
  a_div_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    state != ibci_pkg::ST_DIV |-> div_cnt == '0)
    else $error("division step counter left running");

endmodule
